@@ hdl/gqf_pkg.sv @@
// Package for the Gaussian tail probability block: types, Q30 constants, ALU request types.
package gqf_pkg;

    localparam int FRACTION_ITERATIONS_DEF = 10;
    localparam int INPUT_FRACTION_BITS_DEF = 11;
    localparam int OUTPUT_BITS_DEF         = 16;

    localparam int QW        = 40;   // unsigned Q30 datapath width
    localparam int SW        = 42;   // signed accumulator width
    localparam int EXP_TERMS = 14;

    typedef logic [QW-1:0]        t_q;
    typedef logic signed [SW-1:0] t_s;

    localparam logic [63:0] ONE64 = 64'd1073741824;

    localparam t_q ONE_Q       = t_q'(ONE64);
    localparam t_q INV_SQRT2_Q = t_q'((64'd7071067812 * ONE64 + 64'd5000000000) / 64'd10000000000);
    localparam t_q RSQRTPI_Q   = t_q'((64'd5641895835 * ONE64 + 64'd5000000000) / 64'd10000000000);
    localparam t_q P_Q         = t_q'((64'd3275911 * ONE64 + 64'd5000000) / 64'd10000000);
    localparam t_q A1_M = t_q'((64'd254829592 * ONE64 + 64'd500000000) / 64'd1000000000);
    localparam t_q A2_M = t_q'((64'd284496736 * ONE64 + 64'd500000000) / 64'd1000000000);
    localparam t_q A3_M = t_q'((64'd1421413741 * ONE64 + 64'd500000000) / 64'd1000000000);
    localparam t_q A4_M = t_q'((64'd1453152027 * ONE64 + 64'd500000000) / 64'd1000000000);
    localparam t_q A5_M = t_q'((64'd1061405429 * ONE64 + 64'd500000000) / 64'd1000000000);

    // polynomial coefficients in Horner order after the leading one
    localparam t_s A_TAB [4] = '{
        -$signed({2'b00, A4_M}),
         $signed({2'b00, A3_M}),
        -$signed({2'b00, A2_M}),
         $signed({2'b00, A1_M})
    };
    localparam t_s A5_S = $signed({2'b00, A5_M});

    localparam t_q Y_SMALL_LIM = t_q'(64'd2 * ONE64);
    localparam t_q Y_LARGE_LIM = t_q'(64'd6 * ONE64);

    typedef enum logic {ALU_MUL, ALU_DIV} t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        logic    frac;   // divide: shift dividend left by 30
        t_q      a;
        t_q      b;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic busy;
        t_q   res;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_Y, ST_PY, ST_T, ST_POLY, ST_CF, ST_CFP, ST_Z,
        ST_EM, ST_ED, ST_EP, ST_FIN, ST_OUT
    } t_state;

    function automatic t_q s_mag(input t_s v);
        t_s m;
        m = v[SW-1] ? -v : v;
        return m[QW-1:0];
    endfunction

endpackage

@@ hdl/gqf_alu.sv @@
// Shared Q30 multiply (10 bits a cycle) and restoring divide (one bit a cycle) unit.
module gqf_alu
    import gqf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int MCH = 10;
    localparam int MST = QW / MCH;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    t_alu_op         r_op, n_op;
    logic [5:0]      r_cnt, n_cnt;
    t_q              r_a, n_a;
    t_q              r_b, n_b;
    logic [2*QW-1:0] r_acc, n_acc;
    logic [QW:0]     r_rem, n_rem;
    t_q              r_dq, n_dq;

    logic [QW+MCH-1:0] w_pp;
    logic [QW+1:0]     w_rr;
    logic              w_ge;

    assign w_pp = r_a * r_b[QW-1 -: MCH];
    assign w_rr = {r_rem, r_dq[QW-1]};
    assign w_ge = w_rr >= {2'b00, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_dq   = r_dq;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_op   = i_req.op;
                n_a    = i_req.a;
                n_b    = i_req.b;
                n_acc  = '0;
                if (i_req.frac) begin
                    n_rem = {11'd0, i_req.a[QW-1:10]};
                    n_dq  = {i_req.a[9:0], 30'd0};
                end else begin
                    n_rem = '0;
                    n_dq  = i_req.a;
                end
                n_cnt = (i_req.op == ALU_MUL) ? 6'(MST - 1) : 6'(QW - 1);
            end
        end else begin
            unique case (r_op)
                ALU_MUL: begin
                    n_acc = (r_acc << MCH) + (2*QW)'(w_pp);
                    n_b   = r_b << MCH;
                end
                ALU_DIV: begin
                    n_rem = w_ge ? (QW+1)'(w_rr - {2'b00, r_b}) : w_rr[QW:0];
                    n_dq  = {r_dq[QW-2:0], w_ge};
                end
                default: ;
            endcase
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_dq  <= n_dq;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.res  = (r_op == ALU_MUL) ? r_acc[QW+29:30] : r_dq;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("alu done without operation");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && !r_busy) |=> r_busy) else $error("alu start lost");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == ALU_DIV) |-> (r_rem < {1'b0, r_b})) else $error("divide remainder");
`endif

endmodule

@@ hdl/gaussian_q_function.sv @@
// Top level: Gaussian tail probability Q(x) sequenced over one shared multiply/divide unit.
//
//  channel  | ports                                | handshake
//  ---------+--------------------------------------+------------------------------
//  argument | start, busy, i_argument[15:0]        | beat taken when start & !busy
//  result   | o_valid, o_tail_probability          | one-cycle strobe, no stall
//
//  An argument with |x|/sqrt2 >= 6 goes straight to the result; the longest
//  path is the continued fraction: FRACTION_ITERATIONS+1 divides, two 15-term
//  Taylor series and up to 35 multiplies by exp(-1), all on the shared unit.
//  Reset is synchronous, active low, and returns the sequencer to idle.
//  The result beat is shown for one cycle; a new start is taken in that cycle.
module gaussian_q_function
    import gqf_pkg::*;
#(
    parameter int FRACTION_ITERATIONS = FRACTION_ITERATIONS_DEF,
    parameter int INPUT_FRACTION_BITS = INPUT_FRACTION_BITS_DEF,
    parameter int OUTPUT_BITS         = OUTPUT_BITS_DEF
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [15:0]     i_argument,
    output logic                   o_valid,
    output logic [OUTPUT_BITS-1:0] o_tail_probability
);

    localparam int KMAX = (FRACTION_ITERATIONS > EXP_TERMS) ? FRACTION_ITERATIONS : EXP_TERMS;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int OSH  = 32 - OUTPUT_BITS;
    localparam logic [33:0] HALF = (34'd1 << OSH) >> 1;
    localparam logic [33:0] FULL = 34'd1 << 32;
    localparam logic [33:0] MAXV = (34'd1 << OUTPUT_BITS) - 34'd1;

    t_state  r_state, n_state;
    logic    r_neg, n_neg;
    t_q      r_y, n_y;
    t_q      r_t, n_t;
    t_s      r_s, n_s;
    logic [2:0]    r_cnt, n_cnt;
    logic [KW-1:0] r_k, n_k;
    t_q      r_val, n_val;
    t_q      r_p, n_p;
    t_q      r_z, n_z;
    t_q      r_e1, n_e1;
    t_q      r_e, n_e;
    t_q      r_term, n_term;
    t_s      r_sum, n_sum;
    logic    r_pass, n_pass;
    logic [5:0] r_n, n_n;
    t_q      r_tail, n_tail;
    logic    r_valid, n_valid;
    logic [OUTPUT_BITS-1:0] r_out, n_out;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    logic [15:0] w_mag;
    t_s          w_sprod, w_snew, w_sumn;
    t_q          w_ev, w_valn, w_rexp;
    logic [33:0] w_q32, w_qs, w_rnd;

    gqf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_mag   = i_argument[15] ? 16'(-i_argument) : i_argument;
        w_sprod = r_s[SW-1] ? -$signed({2'b00, w_rsp.res}) : $signed({2'b00, w_rsp.res});
        w_snew  = A_TAB[r_cnt[1:0]] + w_sprod;
        w_sumn  = r_k[0] ? (r_sum - $signed({2'b00, w_rsp.res}))
                         : (r_sum + $signed({2'b00, w_rsp.res}));
        w_ev    = w_sumn[SW-1] ? '0 : w_sumn[QW-1:0];
        w_valn  = r_y + w_rsp.res;
        w_rexp  = {10'd0, r_z[29:0]};
        // output shaping: complement for negative x, round, saturate
        w_q32   = {r_tail[31:0], 2'b00};
        if (w_q32 > FULL) w_q32 = FULL;
        w_qs    = r_neg ? (FULL - w_q32) : w_q32;
        w_rnd   = (w_qs + HALF) >> OSH;
        if (w_rnd > MAXV) w_rnd = MAXV;
    end

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_y     = r_y;
        n_t     = r_t;
        n_s     = r_s;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_val   = r_val;
        n_p     = r_p;
        n_z     = r_z;
        n_e1    = r_e1;
        n_e     = r_e;
        n_term  = r_term;
        n_sum   = r_sum;
        n_pass  = r_pass;
        n_n     = r_n;
        n_tail  = r_tail;
        n_valid = 1'b0;
        n_out   = r_out;
        w_req   = '{start: 1'b0, op: ALU_MUL, frac: 1'b0, a: '0, b: '0};
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_neg   = i_argument[15];
                    w_req   = '{1'b1, ALU_MUL, 1'b0,
                                t_q'({24'd0, w_mag}) << (30 - INPUT_FRACTION_BITS),
                                INV_SQRT2_Q};
                    n_state = ST_Y;
                end
            end
            ST_Y: if (w_rsp.done) begin
                n_y = w_rsp.res;
                if (w_rsp.res >= Y_LARGE_LIM) begin
                    n_tail  = '0;
                    n_state = ST_OUT;
                end else if (w_rsp.res <= Y_SMALL_LIM) begin
                    w_req   = '{1'b1, ALU_MUL, 1'b0, P_Q, w_rsp.res};
                    n_state = ST_PY;
                end else begin
                    n_k     = KW'(FRACTION_ITERATIONS);
                    w_req   = '{1'b1, ALU_DIV, 1'b1,
                                t_q'(FRACTION_ITERATIONS) << 29, w_rsp.res};
                    n_state = ST_CF;
                end
            end
            ST_PY: if (w_rsp.done) begin
                w_req   = '{1'b1, ALU_DIV, 1'b1, ONE_Q, ONE_Q + w_rsp.res};
                n_state = ST_T;
            end
            ST_T: if (w_rsp.done) begin
                n_t     = w_rsp.res;
                n_s     = A5_S;
                n_cnt   = '0;
                w_req   = '{1'b1, ALU_MUL, 1'b0, w_rsp.res, A5_M};
                n_state = ST_POLY;
            end
            ST_POLY: if (w_rsp.done) begin
                if (r_cnt != 3'd4) begin
                    n_s   = w_snew;
                    n_cnt = r_cnt + 3'd1;
                    w_req = '{1'b1, ALU_MUL, 1'b0, r_t, s_mag(w_snew)};
                end else begin
                    n_p     = r_s[SW-1] ? '0 : w_rsp.res;   // negative value clamps to zero
                    w_req   = '{1'b1, ALU_MUL, 1'b0, r_y, r_y};
                    n_state = ST_Z;
                end
            end
            ST_CF: if (w_rsp.done) begin
                n_val = w_valn;
                if (r_k == KW'(1)) begin
                    w_req   = '{1'b1, ALU_DIV, 1'b1, RSQRTPI_Q, w_valn};
                    n_state = ST_CFP;
                end else begin
                    n_k   = r_k - KW'(1);
                    w_req = '{1'b1, ALU_DIV, 1'b1, t_q'(r_k - KW'(1)) << 29, w_valn};
                end
            end
            ST_CFP: if (w_rsp.done) begin
                n_p     = w_rsp.res;
                w_req   = '{1'b1, ALU_MUL, 1'b0, r_y, r_y};
                n_state = ST_Z;
            end
            ST_Z: if (w_rsp.done) begin
                // first Taylor pass gives exp(-1)
                n_z     = w_rsp.res;
                n_pass  = 1'b0;
                n_term  = ONE_Q;
                n_sum   = $signed({2'b00, ONE_Q});
                n_k     = KW'(1);
                w_req   = '{1'b1, ALU_MUL, 1'b0, ONE_Q, ONE_Q};
                n_state = ST_EM;
            end
            ST_EM: if (w_rsp.done) begin
                w_req   = '{1'b1, ALU_DIV, 1'b0, w_rsp.res, t_q'(r_k)};
                n_state = ST_ED;
            end
            ST_ED: if (w_rsp.done) begin
                n_term = w_rsp.res;
                n_sum  = w_sumn;
                if (r_k != KW'(EXP_TERMS)) begin
                    n_k     = r_k + KW'(1);
                    w_req   = '{1'b1, ALU_MUL, 1'b0, w_rsp.res, r_pass ? w_rexp : ONE_Q};
                    n_state = ST_EM;
                end else if (!r_pass) begin
                    n_e1    = w_ev;
                    n_pass  = 1'b1;
                    n_term  = ONE_Q;
                    n_sum   = $signed({2'b00, ONE_Q});
                    n_k     = KW'(1);
                    w_req   = '{1'b1, ALU_MUL, 1'b0, ONE_Q, w_rexp};
                    n_state = ST_EM;
                end else begin
                    n_e = w_ev;
                    n_n = r_z[35:30];
                    if (r_z[35:30] == 6'd0) begin
                        w_req   = '{1'b1, ALU_MUL, 1'b0, r_p, w_ev};
                        n_state = ST_FIN;
                    end else begin
                        w_req   = '{1'b1, ALU_MUL, 1'b0, w_ev, r_e1};
                        n_state = ST_EP;
                    end
                end
            end
            ST_EP: if (w_rsp.done) begin
                n_e = w_rsp.res;
                if (r_n == 6'd1) begin
                    w_req   = '{1'b1, ALU_MUL, 1'b0, r_p, w_rsp.res};
                    n_state = ST_FIN;
                end else begin
                    n_n   = r_n - 6'd1;
                    w_req = '{1'b1, ALU_MUL, 1'b0, w_rsp.res, r_e1};
                end
            end
            ST_FIN: if (w_rsp.done) begin
                n_tail  = w_rsp.res >> 1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_out   = w_rnd[OUTPUT_BITS-1:0];
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_neg  <= n_neg;
        r_y    <= n_y;
        r_t    <= n_t;
        r_s    <= n_s;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_val  <= n_val;
        r_p    <= n_p;
        r_z    <= n_z;
        r_e1   <= n_e1;
        r_e    <= n_e;
        r_term <= n_term;
        r_sum  <= n_sum;
        r_pass <= n_pass;
        r_n    <= n_n;
        r_tail <= n_tail;
        r_out  <= n_out;
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_valid            = r_valid;
    assign o_tail_probability = r_out;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start beat not taken");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_alu_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_rsp.busy) else $error("shared unit running while idle");
    a_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_OUT)) else $error("result without sequence end");
`endif

endmodule
